/* design/two_class_credit_shaper_defines.svh */
// assertion macros shared by the shaper checker
`ifndef TWO_CLASS_CREDIT_SHAPER_DEFINES_SVH
`define TWO_CLASS_CREDIT_SHAPER_DEFINES_SVH

// property that holds in the same cycle
`define TCCS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property whose consequent holds in the cycle after its antecedent
`define TCCS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

/* design/tccs_pkg.sv */
// shared types, constants and sequencer states of the credit shaper
package tccs_pkg;

    localparam int FRACTION_BITS_DEF   = 8;
    localparam int HEADER_OVERHEAD_DEF = 28;
    localparam int DEFAULT_SIZE_DEF    = 1024;
    localparam int QUEUE_DEPTH         = 2;

    localparam logic [15:0] FACE_DOWN0 = 16'd256;
    localparam logic [15:0] FACE_DOWN1 = 16'd257;
    localparam logic [15:0] FACE_UP    = 16'd258;
    localparam logic [1:0]  CLASS_A    = 2'd1;
    localparam logic [1:0]  CLASS_B    = 2'd2;

    localparam logic CFG_BANDWIDTH = 1'b0;
    localparam logic CFG_INTERVAL  = 1'b1;

    localparam logic [23:0] BANDWIDTH_RESET = 24'd125000;
    localparam logic [31:0] INTERVAL_RESET  = 32'd1000000;
    localparam logic [23:0] COUNT_MAX       = 24'hFFFFFF;
    localparam logic [39:0] WIDE_MAX        = 40'hFF_FFFF_FFFF;
    localparam logic [30:0] BUDGET_MAX      = 31'h7FFF_FFFF;

    typedef enum logic [1:0] {DIR_DOWN, DIR_UP, DIR_BYPASS} dir_t;

    typedef struct packed {
        logic        is_data;
        dir_t        dir;
        logic        cls_ok;
        logic        cls_b;
        logic [13:0] payload;
        logic [31:0] elapsed;
    } item_t;

    typedef enum logic [4:0] {
        SQ_IDLE, SQ_AVG_A, SQ_AVG_B, SQ_PLAN, SQ_TA, SQ_USED, SQ_TB,
        SQ_DAVG_A, SQ_DAVG_B, SQ_DPLAN, SQ_QD,
        SQ_P1, SQ_P2, SQ_PM1, SQ_PS1, SQ_P3, SQ_P4, SQ_PM2, SQ_PS2,
        SQ_CLEAR
    } seq_state_t;

endpackage

/* design/tccs_front.sv */
// front end: takes input beats and classifies them by face and class
module tccs_front
    import tccs_pkg::*;
(
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] face_id,
    input  logic [1:0]  name_class,
    input  logic [13:0] payload_size,
    input  logic [31:0] elapsed_ticks,
    input  logic        queue_full,
    output logic        push,
    output item_t       item
);

    always_comb
    begin
        item.is_data = kind;
        if (face_id inside {FACE_DOWN0, FACE_DOWN1})
            item.dir = DIR_DOWN;
        else if (face_id == FACE_UP)
            item.dir = DIR_UP;
        else
            item.dir = DIR_BYPASS;
        item.cls_ok  = name_class inside {CLASS_A, CLASS_B};
        item.cls_b   = (name_class == CLASS_B);
        item.payload = payload_size;
        item.elapsed = elapsed_ticks;
        in_stall     = queue_full;
        push         = in_valid && !queue_full;
    end

endmodule

/* design/tccs_fifo.sv */
// short queue of classified beats between front and back
module tccs_fifo
    import tccs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output logic  full,
    output logic  head_valid,
    output item_t head_item
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    item_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wptr_reg;
    logic [PW-1:0]  rptr_reg;
    logic [CW-1:0]  count_reg;

    function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
        if (p == PW'(QUEUE_DEPTH - 1))
            return '0;
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= bump(wptr_reg);
            if (pop)
                rptr_reg <= bump(rptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rptr_reg];

endmodule

/* design/tccs_div.sv */
// restoring divider, one quotient bit per cycle, numerator pre-shifted by the fraction
module tccs_div #(
    parameter int W  = 50,
    parameter int FB = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [W-1:0]    num,
    input  logic [W-1:0]    den,
    output logic            done,
    output logic [W+FB-1:0] quo
);

    localparam int NW = W + FB;
    localparam int KW = $clog2(NW + 1);

    logic [NW-1:0] num_reg;
    logic [NW-1:0] quo_reg;
    logic [W-1:0]  den_reg;
    logic [W-1:0]  rem_reg;
    logic [KW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [W:0]    rem_sh;
    logic [W:0]    rem_sub;
    logic          ge;

    always_comb
    begin
        rem_sh  = {rem_reg, num_reg[NW-1]};
        rem_sub = rem_sh - {1'b0, den_reg};
        ge      = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {num, {FB{1'b0}}};
            den_reg <= den;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], 1'b0};
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= KW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == KW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* design/tccs_back.sv */
// back end: admission, accounting, budget recomputation sequencer and result register
module tccs_back
    import tccs_pkg::*;
#(
    parameter int FRACTION_BITS   = FRACTION_BITS_DEF,
    parameter int HEADER_OVERHEAD = HEADER_OVERHEAD_DEF,
    parameter int DEFAULT_SIZE    = DEFAULT_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  item_t       q_item,
    output logic        q_pop,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        admit,
    output logic        reject_request,
    output logic        recalculated
);

    localparam int W  = 42 + FRACTION_BITS;
    localparam int NW = W + FRACTION_BITS;
    localparam logic [W-1:0]  HDR_Q = W'(HEADER_OVERHEAD) << FRACTION_BITS;
    localparam logic [W-1:0]  DEF_Q = W'(DEFAULT_SIZE) << FRACTION_BITS;
    localparam logic [31:0]   ONE_Q = 32'(1) << FRACTION_BITS;

    seq_state_t state_reg, state_next;

    logic [23:0]  bw_reg;
    logic [31:0]  interval_reg;
    logic [31:0]  bud_reg [4];
    logic [23:0]  cnt_reg [6];
    logic [39:0]  bytes_reg [4];
    logic [39:0]  time_reg;
    logic [W-1:0] a_reg, b_reg, x_reg, y_reg;
    logic [30:0]  t0_reg, t1_reg;
    logic [61:0]  mul_reg;
    logic         ptgt_reg;
    logic         else_reg;
    logic         issued_reg;
    logic         pend_admit_reg, pend_reject_reg;
    logic         out_valid_reg, admit_reg, reject_reg, recalc_reg;

    logic [W-1:0]  bw_q;
    logic          ia, ib, da, db;
    logic          div_need, div_start, div_done, step;
    logic [W-1:0]  div_n, div_d;
    logic [NW-1:0] div_quo;
    logic [30:0]   qs, ms;
    logic [W-1:0]  used_q;

    logic          out_free, pop, out_load;
    logic [40:0]   time_sum;
    logic [39:0]   time_nx;
    logic [1:0]    bidx;
    logic [2:0]    ci;
    logic [1:0]    bi;
    logic          down_ok, cnt_en, admit_now, reject_now, recalc_now;
    logic [40:0]   bytes_sum;

    function automatic logic [30:0] sat_q(input logic [NW-1:0] q);
        if (|q[NW-1:31])
            return BUDGET_MAX;
        return q[30:0];
    endfunction

    // per-item decode
    always_comb
    begin
        bw_q       = W'(bw_reg) << FRACTION_BITS;
        ia         = cnt_reg[0] > 24'd1;
        ib         = cnt_reg[1] > 24'd1;
        da         = cnt_reg[2] > 24'd1;
        db         = cnt_reg[3] > 24'd1;
        out_free   = !out_valid_reg || !out_stall;
        pop        = (state_reg == SQ_IDLE) && q_valid && out_free;
        time_sum   = {1'b0, time_reg} + 41'(q_item.elapsed);
        time_nx    = time_sum[40] ? WIDE_MAX : time_sum[39:0];
        bidx       = {q_item.is_data, q_item.cls_b};
        down_ok    = (q_item.dir == DIR_DOWN) && q_item.cls_ok && !bud_reg[bidx][31];
        cnt_en     = down_ok || ((q_item.dir == DIR_UP) && q_item.cls_ok && q_item.is_data);
        ci         = (q_item.dir == DIR_UP) ? {2'b10, q_item.cls_b}
                                            : {1'b0, q_item.is_data, q_item.cls_b};
        bi         = {q_item.dir == DIR_UP, q_item.cls_b};
        bytes_sum  = {1'b0, bytes_reg[bi]} + 41'(q_item.payload);
        admit_now  = (q_item.dir == DIR_DOWN) ? down_ok : 1'b1;
        reject_now = !q_item.is_data && !admit_now;
        recalc_now = time_nx > {8'd0, interval_reg};
        out_load   = (pop && !recalc_now) || (state_reg == SQ_CLEAR);
        q_pop      = pop;
    end

    // divider operand selection
    always_comb
    begin
        div_need = 1'b0;
        div_n    = bw_q;
        div_d    = x_reg;
        case (state_reg)
            SQ_AVG_A:
            begin
                div_need = (cnt_reg[4] > 24'd1) || da;
                div_n    = (cnt_reg[4] > 24'd1) ? W'(bytes_reg[2]) : W'(bytes_reg[0]);
                div_d    = (cnt_reg[4] > 24'd1) ? W'(cnt_reg[4]) : W'(cnt_reg[2]);
            end
            SQ_AVG_B:
            begin
                div_need = (cnt_reg[5] > 24'd1) || db;
                div_n    = (cnt_reg[5] > 24'd1) ? W'(bytes_reg[3]) : W'(bytes_reg[1]);
                div_d    = (cnt_reg[5] > 24'd1) ? W'(cnt_reg[5]) : W'(cnt_reg[3]);
            end
            SQ_DAVG_A:
            begin
                div_need = 1'b1;
                div_n    = W'(bytes_reg[0]);
                div_d    = W'(cnt_reg[2]);
            end
            SQ_DAVG_B:
            begin
                div_need = 1'b1;
                div_n    = W'(bytes_reg[1]);
                div_d    = W'(cnt_reg[3]);
            end
            SQ_TA, SQ_QD, SQ_P1:
            begin
                div_need = 1'b1;
            end
            SQ_TB:
            begin
                div_need = 1'b1;
                div_n    = (used_q > bw_q) ? '0 : bw_q - used_q;
                div_d    = y_reg;
            end
            SQ_P2:
            begin
                div_need = 1'b1;
                div_n    = y_reg;
                div_d    = x_reg + y_reg;
            end
            SQ_P3:
            begin
                div_need = 1'b1;
                div_d    = y_reg;
            end
            SQ_P4:
            begin
                div_need = 1'b1;
                div_n    = x_reg;
                div_d    = x_reg + y_reg;
            end
            default:
            begin
                div_need = 1'b0;
            end
        endcase
        div_start = div_need && !issued_reg;
        step      = div_need ? div_done : 1'b1;
        qs        = sat_q(div_quo);
        ms        = (|mul_reg[61:31+FRACTION_BITS]) ? BUDGET_MAX
                                                    : mul_reg[30+FRACTION_BITS:FRACTION_BITS];
        used_q    = W'(mul_reg);
    end

    tccs_div #(.W(W), .FB(FRACTION_BITS)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_n),
        .den   (div_d),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SQ_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE:   if (pop && recalc_now) state_next = SQ_AVG_A;
            SQ_AVG_A:  if (step) state_next = SQ_AVG_B;
            SQ_AVG_B:  if (step) state_next = SQ_PLAN;
            SQ_PLAN:   state_next = (ia && ib) ? SQ_P1 : SQ_TA;
            SQ_TA:
            begin
                if (step)
                    state_next = (else_reg && (da || db)) ? SQ_DAVG_A : SQ_USED;
            end
            SQ_USED:   state_next = SQ_TB;
            SQ_TB:     if (step) state_next = SQ_CLEAR;
            SQ_DAVG_A: if (step) state_next = SQ_DAVG_B;
            SQ_DAVG_B: if (step) state_next = SQ_DPLAN;
            SQ_DPLAN:  state_next = (da && db) ? SQ_P1 : SQ_QD;
            SQ_QD:     if (step) state_next = SQ_CLEAR;
            SQ_P1:     if (step) state_next = SQ_P2;
            SQ_P2:     if (step) state_next = SQ_PM1;
            SQ_PM1:    state_next = SQ_PS1;
            SQ_PS1:    state_next = SQ_P3;
            SQ_P3:     if (step) state_next = SQ_P4;
            SQ_P4:     if (step) state_next = SQ_PM2;
            SQ_PM2:    state_next = SQ_PS2;
            SQ_PS2:    state_next = SQ_CLEAR;
            SQ_CLEAR:  state_next = SQ_IDLE;
            default:   state_next = SQ_IDLE;
        endcase
    end

    // working values of the recomputation
    always_ff @(posedge clk)
    begin
        case (state_reg)
            SQ_AVG_A:  a_reg <= div_need ? div_quo[W-1:0] : DEF_Q;
            SQ_AVG_B:  b_reg <= div_need ? div_quo[W-1:0] : DEF_Q;
            SQ_DAVG_A: a_reg <= div_quo[W-1:0];
            SQ_DAVG_B: b_reg <= div_quo[W-1:0];
            SQ_PLAN:
            begin
                ptgt_reg <= 1'b0;
                else_reg <= !(ia || ib);
                if (ia && ib)
                begin
                    x_reg <= a_reg + HDR_Q;
                    y_reg <= b_reg + HDR_Q;
                end
                else if (ia || ib)
                begin
                    x_reg <= (ia ? a_reg : b_reg) + HDR_Q;
                    y_reg <= ia ? a_reg : b_reg;
                end
                else
                begin
                    x_reg <= DEF_Q + HDR_Q;
                    y_reg <= DEF_Q;
                end
            end
            SQ_DPLAN:
            begin
                ptgt_reg <= 1'b1;
                x_reg    <= (da && !db) ? a_reg : (da ? a_reg : b_reg);
                y_reg    <= b_reg;
            end
            SQ_TA, SQ_P1, SQ_P3: t0_reg <= qs;
            SQ_P2, SQ_P4:        t1_reg <= qs;
            SQ_USED:             mul_reg <= 62'(t0_reg) * 62'(HEADER_OVERHEAD);
            SQ_PM1, SQ_PM2:      mul_reg <= 62'(t0_reg) * 62'(t1_reg);
            default:             mul_reg <= mul_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bw_reg          <= BANDWIDTH_RESET;
            interval_reg    <= INTERVAL_RESET;
            time_reg        <= '0;
            issued_reg      <= 1'b0;
            pend_admit_reg  <= 1'b0;
            pend_reject_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            admit_reg       <= 1'b0;
            reject_reg      <= 1'b0;
            recalc_reg      <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                bud_reg[i]   <= '0;
                bytes_reg[i] <= 40'd1;
            end
            for (int i = 0; i < 6; i++)
                cnt_reg[i] <= 24'd1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BANDWIDTH: bw_reg       <= cfg_data[23:0];
                    CFG_INTERVAL:  interval_reg <= cfg_data;
                    default:       bw_reg       <= bw_reg;
                endcase
            end

            if (div_start)
                issued_reg <= 1'b1;
            else if (div_done)
                issued_reg <= 1'b0;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                SQ_IDLE:
                begin
                    if (pop)
                    begin
                        time_reg <= time_nx;
                        if (down_ok)
                            bud_reg[bidx] <= bud_reg[bidx] - ONE_Q;
                        if (cnt_en && (cnt_reg[ci] != COUNT_MAX))
                        begin
                            cnt_reg[ci] <= cnt_reg[ci] + 24'd1;
                            if (q_item.is_data)
                                bytes_reg[bi] <= bytes_sum[40] ? WIDE_MAX : bytes_sum[39:0];
                        end
                        if (recalc_now)
                        begin
                            pend_admit_reg  <= admit_now;
                            pend_reject_reg <= reject_now;
                        end
                        else
                        begin
                            admit_reg     <= admit_now;
                            reject_reg    <= reject_now;
                            recalc_reg    <= 1'b0;
                        end
                    end
                end
                SQ_TA:
                begin
                    if (div_done)
                    begin
                        bud_reg[0] <= {1'b0, qs};
                        bud_reg[1] <= {1'b0, qs};
                    end
                end
                SQ_TB, SQ_QD:
                begin
                    if (div_done)
                    begin
                        bud_reg[2] <= {1'b0, qs};
                        bud_reg[3] <= {1'b0, qs};
                    end
                end
                SQ_PS1: bud_reg[{ptgt_reg, 1'b0}] <= {1'b0, ms};
                SQ_PS2: bud_reg[{ptgt_reg, 1'b1}] <= {1'b0, ms};
                SQ_CLEAR:
                begin
                    time_reg <= '0;
                    for (int i = 0; i < 4; i++)
                        bytes_reg[i] <= 40'd1;
                    for (int i = 0; i < 6; i++)
                        cnt_reg[i] <= 24'd1;
                    admit_reg     <= pend_admit_reg;
                    reject_reg    <= pend_reject_reg;
                    recalc_reg    <= 1'b1;
                end
                default:
                begin
                    time_reg <= time_reg;
                end
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign admit          = admit_reg;
    assign reject_request = reject_reg;
    assign recalculated   = recalc_reg;

endmodule

/* design/two_class_credit_shaper.sv */
// top level of the two-class credit shaper
// Each packet beat gives exactly one result beat. A packet that does not trigger a budget
// recomputation goes from the queue head straight into the result register, so while out_stall is low
// beats flow at one per cycle through a two-entry queue and a result register. A packet whose
// accumulated time passes the interval starts a recomputation that holds the back end for 2
// to 9 serial divisions plus plan, multiply and clear steps; the divisions run one after another
// on the single shared bit-serial divider.
// Configuration writes take effect on the clock edge at which cfg_we is high.
module two_class_credit_shaper
    import tccs_pkg::*;
#(
    parameter int FRACTION_BITS   = FRACTION_BITS_DEF,
    parameter int HEADER_OVERHEAD = HEADER_OVERHEAD_DEF,
    parameter int DEFAULT_SIZE    = DEFAULT_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [15:0] face_id,
    input  logic [1:0]  name_class,
    input  logic [13:0] payload_size,
    input  logic [31:0] elapsed_ticks,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        admit,
    output logic        reject_request,
    output logic        recalculated,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    logic  queue_full, push, head_valid, pop;
    item_t push_item, head_item;

    tccs_front u_front (
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .face_id       (face_id),
        .name_class    (name_class),
        .payload_size  (payload_size),
        .elapsed_ticks (elapsed_ticks),
        .queue_full    (queue_full),
        .push          (push),
        .item          (push_item)
    );

    tccs_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    tccs_back #(
        .FRACTION_BITS   (FRACTION_BITS),
        .HEADER_OVERHEAD (HEADER_OVERHEAD),
        .DEFAULT_SIZE    (DEFAULT_SIZE)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (head_valid),
        .q_item         (head_item),
        .q_pop          (pop),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .admit          (admit),
        .reject_request (reject_request),
        .recalculated   (recalculated)
    );

endmodule

/* design/tccs_checker.sv */
// port-level checker for the credit shaper and its bind
`include "two_class_credit_shaper_defines.svh"

module tccs_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic admit,
    input logic reject_request,
    input logic recalculated
);

    logic [2:0] pend_reg, pend_next;
    logic       in_beat, out_beat;

    always_comb
    begin
        in_beat   = in_valid && !in_stall;
        out_beat  = out_valid && !out_stall;
        pend_next = pend_reg + 3'(in_beat) - 3'(out_beat);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    `TCCS_ASSERT(a_no_invented, out_valid |-> pend_reg != 3'd0, "result beat without packet")
    `TCCS_ASSERT(a_pend_bound, pend_reg <= 3'd4, "too many packets in flight")
    `TCCS_ASSERT(a_reject_drop, out_valid && reject_request |-> !admit, "reject on admitted packet")
    `TCCS_ASSERT_NEXT(a_valid_hold, out_valid && out_stall, out_valid, "result dropped under stall")
    `TCCS_ASSERT_NEXT(a_data_hold, out_valid && out_stall, $stable(admit) && $stable(reject_request) && $stable(recalculated), "result changed under stall")

endmodule

bind two_class_credit_shaper tccs_checker u_checker (.*);
